// ===== rtl/mmpt_pkg.sv =====
// Shared types and codes for the memory map page translator.
package mmpt_pkg;

  localparam int ADDR_W = 64;
  localparam int REQ_W  = 32;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_APPEND   = 2'd1;
  localparam logic [1:0] CMD_ADDR2NUM = 2'd2;
  localparam logic [1:0] CMD_NUM2ADDR = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic              rsv;
  } region_t;

  typedef struct packed {
    logic             hit;
    logic             skip;
    logic [REQ_W-1:0] ans;
    logic [REQ_W-1:0] num_next;
  } eval_t;

endpackage

// ===== rtl/memory_map_page_translator.sv =====
// Memory map page translator: region table, sequencer and result register.
// Clear and append: result valid the cycle after the request is accepted.
// Queries walk the table one region at a time, each visit a unit prep state then an
// evaluate state, until a hit or the last region; a zero request or empty table skips
// the walk. One request at a time; ready returns once taken.
// Reset (rst, synchronous) empties the table count; table contents stay undefined.
module memory_map_page_translator import mmpt_pkg::*; #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_SHIFT  = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] request, [95:32] region_base, [159:96] region_length,
  // [160] region_is_reserved, [167:161] zero
  input  logic [167:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] answer
  output logic [31:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]   m_axis_tuser
);

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state, state_next;
  logic [IW-1:0]    idx, idx_next;
  logic [CW-1:0]    count;
  logic [1:0]       mode;
  logic [REQ_W-1:0] req;
  logic [REQ_W-1:0] num;
  logic [REQ_W-1:0] ans;
  logic [1:0]       status;

  logic             accept;
  logic             wr_en;
  logic             last;
  region_t          wr_data;
  region_t          rd_data;
  eval_t            ev;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = ans;
  assign m_axis_tuser  = status;

  assign wr_data.base = s_axis_tdata[95:32];
  assign wr_data.len  = s_axis_tdata[159:96];
  assign wr_data.rsv  = s_axis_tdata[160];
  assign wr_en        = accept && (s_axis_tuser == CMD_APPEND) &&
                        (count != CW'(MAX_REGIONS));
  assign last         = ((CW'(idx) + CW'(1)) == count);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next = '0;
          if ((s_axis_tuser == CMD_ADDR2NUM || s_axis_tuser == CMD_NUM2ADDR) &&
              s_axis_tdata[31:0] != '0 && count != '0) begin
            state_next = S_PREP;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_PREP: state_next = S_EVAL;
      S_EVAL: begin
        if (ev.hit || last) begin
          state_next = S_OUT;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = S_PREP;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (accept && s_axis_tuser == CMD_CLEAR) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          mode <= s_axis_tuser;
          req  <= s_axis_tdata[31:0];
          num  <= '0;
          ans  <= '0;
          if (s_axis_tuser == CMD_APPEND) begin
            status <= (count == CW'(MAX_REGIONS)) ? ST_FULL : ST_OK;
          end else if (s_axis_tuser == CMD_CLEAR) begin
            status <= ST_OK;
          end else begin
            // queries start as not found; request zero or empty table ends here
            status <= ST_NOT_FOUND;
          end
        end
      end
      S_EVAL: begin
        num <= ev.num_next;
        if (ev.skip) begin
          req <= ev.num_next;
        end
        if (ev.hit) begin
          ans    <= ev.ans;
          status <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  mmpt_table #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[IW-1:0]),
    .wr_data(wr_data),
    .rd_addr(idx_next),
    .rd_data(rd_data)
  );

  mmpt_unit #(
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_unit (
    .clk      (clk),
    .prep_en  (state == S_PREP),
    .addr_mode(mode == CMD_ADDR2NUM),
    .rd       (rd_data),
    .req      (req),
    .num      (num),
    .ev       (ev)
  );

endmodule

// ===== rtl/mmpt_table.sv =====
// Region table storage: one write port, one registered read port.
module mmpt_table import mmpt_pkg::*; #(
  parameter int MAX_REGIONS = 16
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_REGIONS)-1:0] wr_addr,
  input  region_t                        wr_data,
  input  logic [$clog2(MAX_REGIONS)-1:0] rd_addr,
  output region_t                        rd_data
);

  region_t mem [MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/mmpt_unit.sv =====
// Per-region compare/offset unit, reused for every table entry in a walk.
module mmpt_unit import mmpt_pkg::*; #(
  parameter int PAGE_SHIFT = 12
) (
  input  logic             clk,
  input  logic             prep_en,
  input  logic             addr_mode,
  input  region_t          rd,
  input  logic [REQ_W-1:0] req,
  input  logic [REQ_W-1:0] num,
  output eval_t            ev
);

  logic [ADDR_W:0]   diff;
  logic [ADDR_W:0]   dm1;
  logic [ADDR_W-1:0] len_m1;

  logic [ADDR_W-1:0] n_q;
  logic [ADDR_W-1:0] k_q;
  logic              ge_q;
  logic [REQ_W-1:0]  kn_q;
  logic [REQ_W-1:0]  base_lo_q;
  logic              rsv_q;

  logic              rng_n;
  logic [REQ_W-1:0]  off_n;

  // first stage: req - base, dm1 = req - base - 1, len - 1 and req - num in parallel
  assign diff   = {1'b0, {(ADDR_W-REQ_W){1'b0}}, req} - {1'b0, rd.base};
  assign dm1    = {1'b0, {(ADDR_W-REQ_W){1'b0}}, req} + {1'b0, ~rd.base};
  assign len_m1 = rd.len - {{(ADDR_W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (prep_en) begin
      n_q       <= (rd.len == '0) ? '0 : (len_m1 >> PAGE_SHIFT);
      ge_q      <= ~diff[ADDR_W];
      k_q       <= (diff[ADDR_W-1:0] == '0) ? '0 : (dm1[ADDR_W-1:0] >> PAGE_SHIFT);
      kn_q      <= req - num;
      base_lo_q <= rd.base[REQ_W-1:0];
      rsv_q     <= rd.rsv;
    end
  end

  assign rng_n = {{(ADDR_W-REQ_W){1'b0}}, kn_q} < n_q;
  assign off_n = kn_q << PAGE_SHIFT;

  always_comb begin
    ev.num_next = num + n_q[REQ_W-1:0];
    if (addr_mode) begin
      ev.hit  = ge_q && (k_q < n_q);
      ev.skip = 1'b0;
      ev.ans  = num + k_q[REQ_W-1:0] + {{(REQ_W-1){1'b0}}, 1'b1};
    end else begin
      ev.hit  = rng_n && !rsv_q;
      ev.skip = rng_n && rsv_q;
      ev.ans  = base_lo_q + off_n;
    end
  end

endmodule
